// File: design/sts_pkg.sv
// ============================================================================
// sts_pkg
// Shared constants and types for the sorted table binary search block.
// ============================================================================
package sts_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLS    = 32;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int IDX_W   = $clog2(STORE_DEPTH);  // flat entry index
    localparam int BOUND_W = IDX_W + 1;            // holds STORE_DEPTH itself
    localparam int CNT_W   = 6;                    // row/column count registers
    localparam int DATA_W  = 32;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    // request opcodes
    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

endpackage

// File: design/sts_req_if.sv
// ============================================================================
// sts_req_if
// Request channel: opcode, flat entry index and value with valid/ready.
// ============================================================================
interface sts_req_if
    import sts_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] value;

    modport source (
        output valid, opcode, entry_index, value,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, value,
        output ready
    );
endinterface

// File: design/sts_rsp_if.sv
// ============================================================================
// sts_rsp_if
// Response channel: found flag with valid/ready.
// ============================================================================
interface sts_rsp_if;
    logic valid;
    logic ready;
    logic found;

    modport source (
        output valid, found,
        input  ready
    );

    modport sink (
        input  valid, found,
        output ready
    );
endinterface

// File: design/sorted_table_binary_search.sv
// ============================================================================
// sorted_table_binary_search
// Table of signed 32-bit entries held in a synchronous RAM, with a binary
// search over the first row_count*col_count entries, each count clamped to 32.
// ============================================================================
// Write request: no response; taken even while a response waits.
// Search request: each probe is a RAM read, then a compare and narrow;
//   at most 11 probes for 1024 entries, then S_DONE raises the response.
// One request in flight at a time; the response register frees the search.
// Reset clears row_count, col_count and control state; the RAM is not cleared.
module sorted_table_binary_search
    import sts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready,
    sts_req_if.sink            req,
    sts_rsp_if.source          rsp
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         row_count_reg, col_count_reg;
    logic [BOUND_W-1:0]       lo_reg, lo_next;
    logic [BOUND_W-1:0]       hi_reg, hi_next;
    logic [IDX_W-1:0]         mid_reg, mid_next;
    logic signed [DATA_W-1:0] target_reg, target_next;
    logic                     hit_reg, hit_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;

    logic signed [DATA_W-1:0] mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_en;
    logic                     wr_en;
    logic                     req_fire;
    logic                     cfg_wr;

    logic [CNT_W-1:0]         rows_sat, cols_sat;
    logic [BOUND_W-1:0]       entry_total;
    logic [BOUND_W-1:0]       span;
    logic [BOUND_W-1:0]       mid_full;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ROW_COUNT: row_count_reg <= pwdata[CNT_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_ROW_COUNT: prdata = APB_W'(row_count_reg);
            REG_COL_COUNT: prdata = APB_W'(col_count_reg);
            default:       prdata = '0;
        endcase
    end

    // clamp counts to the table shape
    assign rows_sat    = (row_count_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count_reg;
    assign cols_sat    = (col_count_reg > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : col_count_reg;
    assign entry_total = BOUND_W'(rows_sat) * BOUND_W'(cols_sat);

    // ---------------------------------------------------------------- handshake
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid & req.ready;
    assign wr_en     = req_fire & (req.opcode == OP_WRITE);

    assign rsp.valid = out_valid_reg;
    assign rsp.found = found_reg;

    // midpoint of the half-open window [lo, hi)
    assign span     = hi_reg - lo_reg - BOUND_W'(1);
    assign mid_full = lo_reg + (span >> 1);

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        target_next    = target_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        rd_en          = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.opcode == OP_SEARCH))
                begin
                    lo_next     = '0;
                    hi_next     = entry_total;
                    target_next = req.value;
                    hit_next    = 1'b0;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    mid_next   = mid_full[IDX_W-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                priority if (rd_data_reg == target_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (rd_data_reg < target_reg)
                begin
                    lo_next    = BOUND_W'(mid_reg) + BOUND_W'(1);
                    state_next = S_PROBE;
                end
                else
                begin
                    hi_next    = BOUND_W'(mid_reg);
                    state_next = S_PROBE;
                end
            end
            S_DONE:
            begin
                // hold until the response register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        target_reg <= target_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
    end

    // ---------------------------------------------------------------- table RAM
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[req.entry_index] <= req.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[mid_full[IDX_W-1:0]];
        end
    end

    // ---------------------------------------------------------------- checks
    a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_CMP) |-> (lo_reg <= hi_reg))
        else $error("search window inverted");

    a_window_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_CMP) |-> (hi_reg <= BOUND_W'(STORE_DEPTH)))
        else $error("search window beyond table");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |->
            (BOUND_W'(mid_reg) >= lo_reg) && (BOUND_W'(mid_reg) < hi_reg))
        else $error("probe outside search window");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside search completion");

endmodule
